>>> design/lms_multi_output_regressor_defines.svh
// Assertion macros shared by the regressor checker.
`ifndef LMS_MULTI_OUTPUT_REGRESSOR_DEFINES_SVH
`define LMS_MULTI_OUTPUT_REGRESSOR_DEFINES_SVH

// Consequent checked on the cycle after the antecedent.
`define LMR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmr checker: next-cycle property failed");

// Consequent checked on the same cycle as the antecedent.
`define LMR_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmr checker: same-cycle property failed");

`endif

>>> design/lmr_pkg.sv
// Shared constants, types and codes of the LMS regressor.
package lmr_pkg;

	localparam int NUM_OUTPUTS  = 3;
	localparam int NUM_FEATURES = 7;
	localparam int NUM_WEIGHTS  = NUM_OUTPUTS * NUM_FEATURES;

	localparam int FEAT_W   = 16;
	localparam int WEIGHT_W = 32;
	localparam int RATE_W   = 16;
	localparam int FRAC_W   = 16;

	localparam int OIDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
	localparam int FIDX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int WIDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

	// shared multiplier: A side holds a weight, an error or rate*error, B a feature or rate
	localparam int ERR_W   = FEAT_W + 1;
	localparam int MUL_A_W = RATE_W + ERR_W + 1;
	localparam int MUL_B_W = FEAT_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + FIDX_W;
	localparam int DELTA_W = PROD_W - FRAC_W;
	localparam int WSUM_W  = ((DELTA_W > WEIGHT_W) ? DELTA_W : WEIGHT_W) + 1;

	localparam int IN_DATA_W  = (NUM_FEATURES + NUM_OUTPUTS) * FEAT_W;
	localparam int OUT_DATA_W = NUM_OUTPUTS * FEAT_W;

	localparam int  APB_ADDR_W  = 3;
	localparam int  APB_DATA_W  = 32;
	localparam logic REG_LEARN_RATE = 1'b0;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd66;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_PRED,
		MUL_ERR,
		MUL_UPD
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_PDRAIN,
		ST_ERR,
		ST_REWAIT,
		ST_UPD,
		ST_UDRAIN,
		ST_DONE
	} lmr_state_t;

	typedef struct packed {
		logic              load;
		mul_op_t           op;
		logic [WIDX_W-1:0] widx;
		logic [OIDX_W-1:0] oidx;
		logic [FIDX_W-1:0] fidx;
		logic              first;
		logic              last;
		logic              re_load;
		logic              publish;
	} dp_cmd_t;

	typedef struct packed {
		logic train;
		logic out_free;
	} dp_stat_t;

endpackage

>>> design/lmr_ctrl.sv
// Sequencer: walks the prediction pass and the update pass over the weights.
module lmr_ctrl import lmr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	lmr_state_t        state_q, state_d;
	logic [WIDX_W-1:0] widx_q;
	logic [OIDX_W-1:0] oidx_q;
	logic [FIDX_W-1:0] fidx_q;
	logic              drain_q;
	logic              f_last, w_last, o_last;

	assign f_last = (fidx_q == FIDX_W'(NUM_FEATURES - 1));
	assign w_last = (widx_q == WIDX_W'(NUM_WEIGHTS - 1));
	assign o_last = (oidx_q == OIDX_W'(NUM_OUTPUTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			widx_q  <= '0;
			oidx_q  <= '0;
			fidx_q  <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_PRED, ST_UPD: begin
					widx_q <= widx_q + 1'b1;
					if (f_last) begin
						fidx_q <= '0;
						oidx_q <= oidx_q + 1'b1;
					end else begin
						fidx_q <= fidx_q + 1'b1;
					end
				end
				ST_UDRAIN: drain_q <= ~drain_q;
				ST_IDLE, ST_PDRAIN: begin
					widx_q  <= '0;
					oidx_q  <= '0;
					fidx_q  <= '0;
					drain_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_PRED;
			ST_PRED:   if (w_last) state_d = ST_PDRAIN;
			ST_PDRAIN: state_d = stat.train ? ST_ERR : ST_DONE;
			ST_ERR:    state_d = ST_REWAIT;
			ST_REWAIT: state_d = ST_UPD;
			ST_UPD:    if (f_last) state_d = o_last ? ST_UDRAIN : ST_ERR;
			ST_UDRAIN: if (drain_q) state_d = ST_DONE;
			ST_DONE:   if (stat.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.op    = MUL_NONE;
		cmd.widx  = widx_q;
		cmd.oidx  = oidx_q;
		cmd.fidx  = fidx_q;
		cmd.first = (fidx_q == '0);
		cmd.last  = f_last;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_PRED:   cmd.op = MUL_PRED;
			ST_ERR:    cmd.op = MUL_ERR;
			ST_REWAIT: cmd.re_load = 1'b1;
			ST_UPD:    cmd.op = MUL_UPD;
			ST_DONE:   cmd.publish = stat.out_free;
			default: ;
		endcase
	end

endmodule

>>> design/lmr_dp.sv
// Datapath: weight store, shared multiplier, accumulator, update pipe, result register.
module lmr_dp import lmr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [RATE_W-1:0]     rate,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  in_train,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_clip
);

	logic signed [WEIGHT_W-1:0] w_q    [NUM_WEIGHTS];
	logic signed [FEAT_W-1:0]   feat_q [NUM_FEATURES];
	logic signed [FEAT_W-1:0]   want_q [NUM_OUTPUTS];
	logic signed [FEAT_W-1:0]   pred_q [NUM_OUTPUTS];
	logic                       train_q;
	logic                       hit_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [MUL_A_W-1:0]  re_q;

	// stage 1: registered product and its tags
	mul_op_t                    op_s1;
	logic signed [PROD_W-1:0]   product_s1;
	logic [OIDX_W-1:0]          oidx_s1;
	logic [WIDX_W-1:0]          widx_s1;
	logic                       first_s1, last_s1;
	logic signed [WEIGHT_W-1:0] w_s1;
	// stage 2: rounded weight step
	logic                       upd_s2;
	logic [WIDX_W-1:0]          widx_s2;
	logic signed [WEIGHT_W-1:0] w_s2;
	logic signed [DELTA_W-1:0]  delta_s2;

	logic                       out_valid_q, out_clip_q;
	logic [OUT_DATA_W-1:0]      out_data_q;

	logic signed [WEIGHT_W-1:0] w_rd;
	logic signed [FEAT_W-1:0]   feat_sel, want_sel, pred_sel;
	logic signed [ERR_W-1:0]    err;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]    acc_sum;
	logic                       pred_ovf;
	logic signed [FEAT_W-1:0]   pred_sat;
	logic signed [PROD_W-1:0]   prod_rnd;
	logic signed [WSUM_W-1:0]   w_sum;
	logic                       w_ovf;
	logic signed [WEIGHT_W-1:0] w_sat;

	assign w_rd     = w_q[cmd.widx];
	assign feat_sel = feat_q[cmd.fidx];
	assign want_sel = want_q[cmd.oidx];
	assign pred_sel = pred_q[cmd.oidx];
	assign err      = ERR_W'(want_sel) - ERR_W'(pred_sel);

	always_comb begin
		case (cmd.op)
			MUL_PRED: begin
				mul_a = MUL_A_W'(w_rd);
				mul_b = MUL_B_W'(feat_sel);
			end
			MUL_ERR: begin
				mul_a = MUL_A_W'(err);
				mul_b = $signed({1'b0, rate});
			end
			MUL_UPD: begin
				mul_a = re_q;
				mul_b = MUL_B_W'(feat_sel);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// start each row at the rounding bias so one add finishes the sum
	assign acc_sum  = (first_s1 ? ACC_W'(1 << (FRAC_W - 1)) : acc_q) + ACC_W'(product_s1);
	assign pred_ovf = !((&acc_sum[ACC_W-1:FRAC_W+FEAT_W-1]) ||
	                    !(|acc_sum[ACC_W-1:FRAC_W+FEAT_W-1]));
	assign pred_sat = pred_ovf ? (acc_sum[ACC_W-1] ? {1'b1, {(FEAT_W-1){1'b0}}}
	                                               : {1'b0, {(FEAT_W-1){1'b1}}})
	                           : acc_sum[FRAC_W+FEAT_W-1:FRAC_W];

	assign prod_rnd = product_s1 + PROD_W'(1 << (FRAC_W - 1));

	assign w_sum = WSUM_W'(w_s2) + WSUM_W'(delta_s2);
	assign w_ovf = !((&w_sum[WSUM_W-1:WEIGHT_W-1]) || !(|w_sum[WSUM_W-1:WEIGHT_W-1]));
	assign w_sat = w_ovf ? (w_sum[WSUM_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
	                                        : {1'b0, {(WEIGHT_W-1){1'b1}}})
	                     : w_sum[WEIGHT_W-1:0];

	// weight store: one read port at the sequencer index, one write port from stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_WEIGHTS; k++) w_q[k] <= '0;
		end else if (upd_s2) begin
			w_q[widx_s2] <= w_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= MUL_NONE;
			upd_s2      <= 1'b0;
			hit_q       <= 1'b0;
			train_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			op_s1  <= cmd.op;
			upd_s2 <= (op_s1 == MUL_UPD);
			if (cmd.load) begin
				train_q <= in_train;
				hit_q   <= 1'b0;
			end else if (((op_s1 == MUL_PRED) && last_s1 && pred_ovf) || (upd_s2 && w_ovf)) begin
				hit_q <= 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int j = 0; j < NUM_FEATURES; j++)
				feat_q[j] <= in_data[j*FEAT_W +: FEAT_W];
			for (int i = 0; i < NUM_OUTPUTS; i++)
				want_q[i] <= in_data[(NUM_FEATURES+i)*FEAT_W +: FEAT_W];
		end
		product_s1 <= mul_a * mul_b;
		oidx_s1    <= cmd.oidx;
		widx_s1    <= cmd.widx;
		first_s1   <= cmd.first;
		last_s1    <= cmd.last;
		w_s1       <= w_rd;
		widx_s2    <= widx_s1;
		w_s2       <= w_s1;
		delta_s2   <= prod_rnd[PROD_W-1:FRAC_W];
		if (op_s1 == MUL_PRED) begin
			acc_q <= acc_sum;
			if (last_s1) pred_q[oidx_s1] <= pred_sat;
		end
		if (cmd.re_load) re_q <= product_s1[MUL_A_W-1:0];
		if (cmd.publish) begin
			for (int i = 0; i < NUM_OUTPUTS; i++)
				out_data_q[i*FEAT_W +: FEAT_W] <= pred_q[i];
			out_clip_q <= hit_q;
		end
	end

	assign stat.train    = train_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;
	assign out_clip      = out_clip_q;

endmodule

>>> design/lms_multi_output_regressor.sv
// Top level of the online LMS regressor: stream ports, APB register, sequencer and datapath.
//
// Input stream (s_axis): one item per handshake. tuser[0] is the command
// (0 predict, 1 predict then train); tdata carries seven Q7.8 features
// followed by three Q7.8 targets. Output stream (m_axis): one item per
// input item, holding the three Q7.8 predictions made with the weights as
// they stood before the item, and a saturation flag in tuser[0].
// Timing: one item is worked at a time, with a single shared multiplier
// stepping through the 21 weights. A predict item runs the products, a
// drain step and a publish step, then goes back to idle; a train item
// puts one error-times-rate product, one load step and seven weight
// updates per output, and then a drain of the update pipe, between the
// drain step and the publish step.
// The result sits in an output register, so a new item is accepted while
// the previous result still waits; a stalled receiver only holds the
// block once a second result is ready.
// Reset clears all weights to zero and sets learn_rate to 66 (about 0.001).
// The user must write learn_rate over APB at byte address 0 only while the
// block is idle; the block itself does not enforce it.
module lms_multi_output_regressor import lmr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// input items
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, pos_z, orient_w, orient_x,
	                                             // orient_y, orient_z, want_a, want_b, want_c
	input  logic [0:0]            s_axis_tuser,  // command
	// result items
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // pred_a, pred_b, pred_c
	output logic [0:0]            m_axis_tuser   // clipped
);

	logic [RATE_W-1:0] rate_q;
	logic              reg_sel;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	// register index is the word address
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_LEARN_RATE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DATA_W'(rate_q) : '0;

	// hold learn_rate; take a write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	lmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lmr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.rate      (rate_q),
		.in_data   (s_axis_tdata),
		.in_train  (s_axis_tuser[0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_clip  (m_axis_tuser[0])
	);

endmodule

>>> design/lmr_checker.sv
// Port-level checker for the regressor, bound to the top level.
`include "lms_multi_output_regressor_defines.svh"

module lmr_checker import lmr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata,
	input logic                  pready,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [0:0]            m_axis_tuser
);

	logic out_stall;
	logic rate_wr;
	logic rate_rd;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign rate_wr   = psel && penable && pwrite && pready &&
	                   (paddr[APB_ADDR_W-1] == REG_LEARN_RATE);
	assign rate_rd   = psel && !pwrite && (paddr[APB_ADDR_W-1] == REG_LEARN_RATE);

	// a stalled result holds
	`LMR_ASSERT_NEXT(a_out_stall_hold, out_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
	// an accepted item keeps the block busy in the following cycle
	`LMR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// a fresh result comes with the input side free again
	`LMR_ASSERT_NOW(a_result_frees_input, $rose(m_axis_tvalid), s_axis_tready)
	// learn_rate reads back what was written
	`LMR_ASSERT_NEXT(a_rate_readback, rate_wr, !rate_rd || (prdata[RATE_W-1:0] == $past(pwdata[RATE_W-1:0])))

endmodule

bind lms_multi_output_regressor lmr_checker u_lmr_checker (.*);
